### src/fcpbc_pkg.sv
// Shared types for the flow class packet and byte counter.
// Holds operation codes, controller states, result selects and the
// command and status bundles between the controller and the datapath.
package fcpbc_pkg;

  typedef enum logic [1:0] {
    OP_RECORD = 2'd0,
    OP_QUERY  = 2'd1,
    OP_TOTALS = 2'd2,
    OP_CLEAR  = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_HIT,
    ST_UPDATE
  } state_t;

  typedef enum logic [2:0] {
    RES_ZERO,
    RES_TOTALS,
    RES_ENTRY,
    RES_NEW,
    RES_OVF,
    RES_SUM
  } res_sel_t;

  typedef struct packed {
    logic     req_load;
    logic     tot_add;
    logic     fill_clr;
    logic     alloc;
    logic     scan_inc;
    logic     sum_load;
    logic     cnt_wr;
    logic     res_load;
    res_sel_t res_sel;
  } cmd_t;

  typedef struct packed {
    opcode_t op;
    logic    hit;
    logic    last;
    logic    empty;
    logic    full;
  } status_t;

endpackage

### src/fcpbc_ctrl.sv
// Controller state machine for the flow class counter.
// Depends on fcpbc_pkg; drives cmd_t to fcpbc_dp and reads status_t back.
module fcpbc_ctrl
  import fcpbc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  output logic    busy,
  input  status_t sts,
  output cmd_t    cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.res_sel = RES_ZERO;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.req_load = 1'b1;
          state_nxt    = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (sts.op)
          OP_TOTALS: begin
            cmd.res_load = 1'b1;
            cmd.res_sel  = RES_TOTALS;
            state_nxt    = ST_IDLE;
          end
          OP_CLEAR: begin
            cmd.fill_clr = 1'b1;
            cmd.res_load = 1'b1;
            cmd.res_sel  = RES_ZERO;
            state_nxt    = ST_IDLE;
          end
          default: begin
            cmd.tot_add = (sts.op == OP_RECORD);
            if (sts.empty) begin
              cmd.res_load = 1'b1;
              state_nxt    = ST_IDLE;
              if (sts.op == OP_QUERY) begin
                cmd.res_sel = RES_ZERO;
              end else begin
                cmd.alloc   = 1'b1;
                cmd.res_sel = RES_NEW;
              end
            end else begin
              state_nxt = ST_SCAN_RD;
            end
          end
        endcase
      end
      ST_SCAN_RD: begin
        state_nxt = ST_SCAN_CMP;
      end
      ST_SCAN_CMP: begin
        if (sts.hit) begin
          state_nxt = ST_HIT;
        end else if (sts.last) begin
          cmd.res_load = 1'b1;
          state_nxt    = ST_IDLE;
          if (sts.op == OP_QUERY) begin
            cmd.res_sel = RES_ZERO;
          end else if (sts.full) begin
            cmd.res_sel = RES_OVF;
          end else begin
            cmd.alloc   = 1'b1;
            cmd.res_sel = RES_NEW;
          end
        end else begin
          cmd.scan_inc = 1'b1;
          state_nxt    = ST_SCAN_RD;
        end
      end
      ST_HIT: begin
        if (sts.op == OP_QUERY) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = RES_ENTRY;
          state_nxt    = ST_IDLE;
        end else begin
          cmd.sum_load = 1'b1;
          state_nxt    = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd.cnt_wr   = 1'b1;
        cmd.res_load = 1'b1;
        cmd.res_sel  = RES_SUM;
        state_nxt    = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

### src/fcpbc_dp.sv
// Datapath for the flow class counter: request registers, key and count
// memories, fill count, totals and result registers. Depends on fcpbc_pkg.
module fcpbc_dp
  import fcpbc_pkg::*;
#(
  parameter int TABLE_ENTRIES = 64
)
(
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output status_t     sts,
  input  logic [1:0]  in_opcode,
  input  logic [3:0]  in_proto_code,
  input  logic [15:0] in_port_number,
  input  logic [15:0] in_packet_length,
  output logic        out_valid,
  output logic [63:0] out_packet_count,
  output logic [63:0] out_byte_count,
  output logic        out_class_found,
  output logic        out_table_overflow
);

  localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int FW = $clog2(TABLE_ENTRIES + 1);

  opcode_t        op_r;
  logic [19:0]    key_r;
  logic [15:0]    len_r;
  logic [AW-1:0]  scan_idx_r;
  logic [FW-1:0]  fill_r;
  logic [63:0]    tot_pk_r;
  logic [63:0]    tot_by_r;
  logic [63:0]    sum_pk_r;
  logic [63:0]    sum_by_r;

  logic [19:0]    key_mem [TABLE_ENTRIES];
  logic [127:0]   cnt_mem [TABLE_ENTRIES];
  logic [19:0]    key_q;
  logic [127:0]   cnt_q;

  logic [AW-1:0]  cnt_wr_addr;
  logic [127:0]   cnt_wr_data;
  logic           cnt_we;

  logic           out_valid_r;
  logic [63:0]    out_pk_r;
  logic [63:0]    out_by_r;
  logic           out_found_r;
  logic           out_ovf_r;

  always_ff @(posedge clk) begin
    if (cmd.req_load) begin
      op_r  <= opcode_t'(in_opcode);
      key_r <= {in_proto_code, in_port_number};
      len_r <= in_packet_length;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_idx_r <= '0;
    end else if (cmd.req_load) begin
      scan_idx_r <= '0;
    end else if (cmd.scan_inc) begin
      scan_idx_r <= scan_idx_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (cmd.fill_clr) begin
      fill_r <= '0;
    end else if (cmd.alloc) begin
      fill_r <= fill_r + FW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tot_pk_r <= '0;
      tot_by_r <= '0;
    end else if (cmd.tot_add) begin
      tot_pk_r <= tot_pk_r + 64'd1;
      tot_by_r <= tot_by_r + {48'd0, len_r};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sum_load) begin
      sum_pk_r <= cnt_q[127:64] + 64'd1;
      sum_by_r <= cnt_q[63:0] + {48'd0, len_r};
    end
  end

  assign cnt_we      = cmd.alloc | cmd.cnt_wr;
  assign cnt_wr_addr = cmd.alloc ? fill_r[AW-1:0] : scan_idx_r;
  assign cnt_wr_data = cmd.alloc ? {64'd1, 48'd0, len_r} : {sum_pk_r, sum_by_r};

  always_ff @(posedge clk) begin
    if (cmd.alloc) begin
      key_mem[fill_r[AW-1:0]] <= key_r;
    end
    key_q <= key_mem[scan_idx_r];
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_wr_addr] <= cnt_wr_data;
    end
    cnt_q <= cnt_mem[scan_idx_r];
  end

  assign sts.op    = op_r;
  assign sts.hit   = (key_q == key_r);
  assign sts.last  = ((FW'(scan_idx_r) + FW'(1)) == fill_r);
  assign sts.empty = (fill_r == '0);
  assign sts.full  = (fill_r == FW'(TABLE_ENTRIES));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.res_load;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      case (cmd.res_sel)
        RES_TOTALS: begin
          out_pk_r    <= tot_pk_r;
          out_by_r    <= tot_by_r;
          out_found_r <= 1'b0;
          out_ovf_r   <= 1'b0;
        end
        RES_ENTRY: begin
          out_pk_r    <= cnt_q[127:64];
          out_by_r    <= cnt_q[63:0];
          out_found_r <= 1'b1;
          out_ovf_r   <= 1'b0;
        end
        RES_NEW: begin
          out_pk_r    <= 64'd1;
          out_by_r    <= {48'd0, len_r};
          out_found_r <= 1'b1;
          out_ovf_r   <= 1'b0;
        end
        RES_OVF: begin
          out_pk_r    <= '0;
          out_by_r    <= '0;
          out_found_r <= 1'b0;
          out_ovf_r   <= 1'b1;
        end
        RES_SUM: begin
          out_pk_r    <= sum_pk_r;
          out_by_r    <= sum_by_r;
          out_found_r <= 1'b1;
          out_ovf_r   <= 1'b0;
        end
        default: begin
          out_pk_r    <= '0;
          out_by_r    <= '0;
          out_found_r <= 1'b0;
          out_ovf_r   <= 1'b0;
        end
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_packet_count   = out_pk_r;
  assign out_byte_count     = out_by_r;
  assign out_class_found    = out_found_r;
  assign out_table_overflow = out_ovf_r;

endmodule

### src/flow_class_packet_byte_counter.sv
// Top level of the flow class packet and byte counter.
// Joins fcpbc_ctrl and fcpbc_dp; depends on fcpbc_pkg.
//
//   channel  | handshake        | payload
//   ---------+------------------+-----------------------------------------------
//   request  | start / busy     | in_opcode, in_proto_code, in_port_number,
//            |                  | in_packet_length
//   result   | out_valid strobe | out_packet_count, out_byte_count,
//            |                  | out_class_found, out_table_overflow
//
// Totals and clear requests load their result in the dispatch state, and the
// out_valid strobe is registered from that load. Record and query scan the key
// memory linearly, through a read state and a compare state per stored class
// (single read port, registered data); a hit on a record adds an update state.
// Occupied entries form a prefix tracked by a fill count, so reset and clear
// take effect at once with no sweep. Synchronous active-low reset.
// The result strobe lasts one cycle and is never held off; a new request is
// taken during it.
module flow_class_packet_byte_counter
  import fcpbc_pkg::*;
#(
  parameter int TABLE_ENTRIES = 64
)
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_opcode,
  input  logic [3:0]  in_proto_code,
  input  logic [15:0] in_port_number,
  input  logic [15:0] in_packet_length,
  output logic        out_valid,
  output logic [63:0] out_packet_count,
  output logic [63:0] out_byte_count,
  output logic        out_class_found,
  output logic        out_table_overflow
);

  cmd_t    cmd;
  status_t sts;

  fcpbc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  fcpbc_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_opcode          (in_opcode),
    .in_proto_code      (in_proto_code),
    .in_port_number     (in_port_number),
    .in_packet_length   (in_packet_length),
    .out_valid          (out_valid),
    .out_packet_count   (out_packet_count),
    .out_byte_count     (out_byte_count),
    .out_class_found    (out_class_found),
    .out_table_overflow (out_table_overflow)
  );

endmodule
